>>> rtl/mono_framebuffer_dirty_flush_macros.svh
// Assertion macros for the monochrome frame buffer block.
// Used by the checker module; no other dependencies.
`ifndef MONO_FRAMEBUFFER_DIRTY_FLUSH_MACROS_SVH
`define MONO_FRAMEBUFFER_DIRTY_FLUSH_MACROS_SVH

// Same-cycle implication under reset.
`define MFDF_ASSERT_IMP(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error("mfdf same-cycle check failed");

// Next-cycle implication under reset.
`define MFDF_ASSERT_NXT(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
        else $error("mfdf next-cycle check failed");

`endif

>>> rtl/mfdf_pkg.sv
// Shared types, codes and defaults for the monochrome frame buffer block.
// No dependencies.
package mfdf_pkg;

    localparam int WIDTH_PIXELS_DEF = 128;
    localparam int PAGES_DEF        = 8;
    localparam int CHIP_COLUMNS_DEF = 64;

    localparam int PG_W = 4;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_PLOT  = 3'd1;
    localparam logic [2:0] CMD_FILL  = 3'd2;
    localparam logic [2:0] CMD_CLEAR = 3'd3;
    localparam logic [2:0] CMD_FLUSH = 3'd4;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_DRAW  = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_FLUSH = 3'd3;
    localparam logic [2:0] OP_NOP   = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BORDER = 2'd1;
    localparam logic [1:0] ST_BUSY   = 2'd2;
    localparam logic [1:0] ST_IDLE   = 2'd3;

    localparam logic [1:0] CS_LEFT  = 2'd0;
    localparam logic [1:0] CS_RIGHT = 2'd1;
    localparam logic [1:0] CS_BOTH  = 2'd2;

    localparam logic [7:0] LCD_PAGE_BASE   = 8'hB8;
    localparam logic [7:0] LCD_COLUMN_ZERO = 8'h40;

    typedef struct packed {
        logic [2:0]      kind;
        logic            border;
        logic            empty;
        logic            inverse;
        logic [6:0]      x_first;
        logic [7:0]      x_last;
        logic [PG_W-1:0] page_first;
        logic [PG_W-1:0] page_last;
        logic [2:0]      bit_first;
        logic [2:0]      bit_last;
    } op_t;

    typedef struct packed {
        logic [1:0] status;
        logic       bus_valid;
        logic [7:0] bus_byte;
        logic       bus_is_data;
        logic [1:0] chip_select;
        logic       flush_last;
    } result_t;

endpackage

>>> rtl/mfdf_front.sv
// Front end: accepts input items and decodes them into operations.
// Depends on mfdf_pkg.
module mfdf_front #(
    parameter int WIDTH_PIXELS = mfdf_pkg::WIDTH_PIXELS_DEF,
    parameter int PAGES        = mfdf_pkg::PAGES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [2:0]       cmd,
    input  logic [6:0]       x,
    input  logic [5:0]       y,
    input  logic [7:0]       length,
    input  logic [6:0]       height,
    input  logic             inverse,
    input  logic             init_busy,
    output logic             q_push,
    output mfdf_pkg::op_t    q_op,
    input  logic             q_full
);
    import mfdf_pkg::*;

    localparam logic [8:0] W9 = 9'(WIDTH_PIXELS);
    localparam logic [7:0] R8 = 8'(PAGES * 8);

    logic f_valid_reg;
    op_t  f_op_reg;
    op_t  dec;
    logic accept;
    logic [7:0] len_e;
    logic [6:0] hgt_e;
    logic [8:0] xs;
    logic [7:0] ys;
    logic [7:0] y_last;

    always_comb
    begin
        if (cmd == CMD_PLOT)
        begin
            len_e = 8'd1;
            hgt_e = 7'd1;
        end
        else
        begin
            len_e = length;
            hgt_e = height;
        end
        xs     = {2'b00, x} + {1'b0, len_e};
        ys     = {2'b00, y} + {1'b0, hgt_e};
        y_last = ys - 8'd1;

        dec            = '0;
        dec.border     = ({2'b00, x} >= W9) || ({2'b00, y} >= R8) || (xs > W9) || (ys > R8);
        dec.empty      = (len_e == 8'd0) || (hgt_e == 7'd0);
        dec.inverse    = inverse;
        dec.x_first    = x;
        dec.x_last     = 8'(xs - 9'd1);
        dec.page_first = PG_W'(y[5:3]);
        dec.page_last  = PG_W'(y_last[6:3]);
        dec.bit_first  = y[2:0];
        dec.bit_last   = y_last[2:0];
        unique case (cmd)
            CMD_TICK:  dec.kind = OP_TICK;
            CMD_PLOT:  dec.kind = OP_DRAW;
            CMD_FILL:  dec.kind = OP_DRAW;
            CMD_CLEAR: dec.kind = OP_CLEAR;
            CMD_FLUSH: dec.kind = OP_FLUSH;
            default:   dec.kind = OP_NOP;
        endcase
    end

    assign full   = init_busy || (f_valid_reg && q_full);
    assign accept = push && !full;
    assign q_push = f_valid_reg && !q_full;
    assign q_op   = f_op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            f_valid_reg <= 1'b1;
        end
        else if (!q_full)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_op_reg <= dec;
        end
    end

endmodule

>>> rtl/mfdf_queue.sv
// Two-entry queue of decoded operations between front and back end.
// Depends on mfdf_pkg.
module mfdf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  mfdf_pkg::op_t wr_op,
    output logic          q_full,
    output logic          q_valid,
    output mfdf_pkg::op_t rd_op,
    input  logic          rd
);
    import mfdf_pkg::*;

    op_t        slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_wr;
    logic       do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign rd_op   = slot_reg[rd_ptr_reg];
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

>>> rtl/mfdf_back.sv
// Back end: frame store, watermarks, flush sequencer and result register.
// Depends on mfdf_pkg.
module mfdf_back #(
    parameter int WIDTH_PIXELS = mfdf_pkg::WIDTH_PIXELS_DEF,
    parameter int PAGES        = mfdf_pkg::PAGES_DEF,
    parameter int CHIP_COLUMNS = mfdf_pkg::CHIP_COLUMNS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  mfdf_pkg::op_t     q_op,
    output logic              q_pop,
    output logic              init_busy,
    output logic              out_valid,
    output mfdf_pkg::result_t out_res,
    input  logic              out_pop
);
    import mfdf_pkg::*;

    localparam int STORE      = WIDTH_PIXELS * PAGES;
    localparam int AW         = $clog2(STORE);
    localparam int PAGE_STEPS = 2 + 2 * CHIP_COLUMNS;
    localparam int STEP_W     = $clog2(PAGE_STEPS);

    localparam logic [2:0] S_CLR     = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_FILL_RD = 3'd2;
    localparam logic [2:0] S_FILL_WR = 3'd3;
    localparam logic [2:0] S_TICK    = 3'd4;

    logic [7:0] mem [STORE];
    logic [7:0] rdata_reg;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [7:0]    mem_wdata;

    logic [2:0]        state_reg, state_next;
    logic              init_reg, init_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [PG_W-1:0]   low_page_reg, low_page_next;
    logic [PG_W-1:0]   high_page_reg, high_page_next;
    logic              dirty_reg, dirty_next;
    logic              active_reg, active_next;
    logic [PG_W-1:0]   fpage_reg, fpage_next;
    logic [PG_W-1:0]   fend_reg, fend_next;
    logic [STEP_W-1:0] step_reg, step_next;
    op_t               op_reg, op_next;
    logic [7:0]        col_reg, col_next;
    logic [PG_W-1:0]   page_reg, page_next;
    logic              out_valid_reg, out_valid_next;
    result_t           res_reg, res_next;

    logic              out_load;
    result_t           res_new;
    logic              do_adv;
    logic [STEP_W-1:0] tick_j;
    logic              tick_col_ok;
    logic [AW-1:0]     tick_addr;
    logic [AW-1:0]     fill_addr;
    logic              step_last;
    logic              page_done;
    logic [2:0]        mask_lo;
    logic [2:0]        mask_hi;
    logic [7:0]        mask;

    assign tick_j      = step_reg - STEP_W'(2);
    assign tick_col_ok = (32'(tick_j) < WIDTH_PIXELS);
    assign tick_addr   = tick_col_ok ? AW'(32'(fpage_reg) * WIDTH_PIXELS + 32'(tick_j)) : '0;
    assign fill_addr   = AW'(32'(page_reg) * WIDTH_PIXELS + 32'(col_reg));
    assign step_last   = (step_reg == STEP_W'(PAGE_STEPS - 1));
    assign page_done   = (fpage_reg >= fend_reg);
    assign mask_lo     = (page_reg == op_reg.page_first) ? op_reg.bit_first : 3'd0;
    assign mask_hi     = (page_reg == op_reg.page_last) ? op_reg.bit_last : 3'd7;
    assign mask        = (8'hFF << mask_lo) & (8'hFF >> (3'd7 - mask_hi));

    assign init_busy = (state_reg == S_CLR) && init_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        clr_cnt_next   = clr_cnt_reg;
        low_page_next  = low_page_reg;
        high_page_next = high_page_reg;
        dirty_next     = dirty_reg;
        active_next    = active_reg;
        fpage_next     = fpage_reg;
        fend_next      = fend_reg;
        step_next      = step_reg;
        op_next        = op_reg;
        col_next       = col_reg;
        page_next      = page_reg;
        mem_addr       = tick_addr;
        mem_we         = 1'b0;
        mem_wdata      = 8'd0;
        q_pop          = 1'b0;
        out_load       = 1'b0;
        res_new        = '0;
        do_adv         = 1'b0;

        unique case (state_reg)
            S_CLR:
            begin
                mem_addr     = clr_cnt_reg;
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(STORE - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = S_IDLE;
                    init_next    = 1'b0;
                    if (!init_reg)
                    begin
                        out_load       = 1'b1;
                        res_new.status = ST_OK;
                    end
                end
            end
            S_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    q_pop = 1'b1;
                    if (q_op.kind == OP_TICK)
                    begin
                        if (!active_reg)
                        begin
                            out_load       = 1'b1;
                            res_new.status = ST_IDLE;
                        end
                        else if (step_reg < STEP_W'(2))
                        begin
                            out_load            = 1'b1;
                            res_new.bus_valid   = 1'b1;
                            res_new.chip_select = CS_BOTH;
                            res_new.bus_byte    = (step_reg == '0) ?
                                LCD_PAGE_BASE + 8'(fpage_reg) : LCD_COLUMN_ZERO;
                            do_adv              = 1'b1;
                        end
                        else
                        begin
                            state_next = S_TICK;
                        end
                    end
                    else if (q_op.kind == OP_NOP)
                    begin
                        out_load       = 1'b1;
                        res_new.status = ST_IDLE;
                    end
                    else if (active_reg)
                    begin
                        out_load       = 1'b1;
                        res_new.status = ST_BUSY;
                    end
                    else if (q_op.kind == OP_DRAW)
                    begin
                        if (q_op.border)
                        begin
                            out_load       = 1'b1;
                            res_new.status = ST_BORDER;
                        end
                        else if (q_op.empty)
                        begin
                            out_load       = 1'b1;
                            res_new.status = ST_OK;
                        end
                        else
                        begin
                            if (q_op.page_first < low_page_reg)
                            begin
                                low_page_next = q_op.page_first;
                            end
                            if (q_op.page_last > high_page_reg)
                            begin
                                high_page_next = q_op.page_last;
                            end
                            dirty_next = 1'b1;
                            op_next    = q_op;
                            col_next   = {1'b0, q_op.x_first};
                            page_next  = q_op.page_first;
                            state_next = S_FILL_RD;
                        end
                    end
                    else if (q_op.kind == OP_CLEAR)
                    begin
                        low_page_next  = '0;
                        high_page_next = PG_W'(PAGES - 1);
                        dirty_next     = 1'b1;
                        state_next     = S_CLR;
                    end
                    else
                    begin
                        out_load = 1'b1;
                        if (!dirty_reg)
                        begin
                            res_new.status = ST_IDLE;
                        end
                        else
                        begin
                            res_new.status = ST_OK;
                            fpage_next     = low_page_reg;
                            fend_next      = (high_page_reg < low_page_reg) ?
                                low_page_reg : high_page_reg;
                            step_next      = '0;
                            active_next    = 1'b1;
                        end
                    end
                end
            end
            S_FILL_RD:
            begin
                mem_addr   = fill_addr;
                state_next = S_FILL_WR;
            end
            S_FILL_WR:
            begin
                mem_addr   = fill_addr;
                mem_we     = 1'b1;
                mem_wdata  = op_reg.inverse ? (rdata_reg & ~mask) : (rdata_reg | mask);
                state_next = S_FILL_RD;
                if (col_reg == op_reg.x_last)
                begin
                    col_next = {1'b0, op_reg.x_first};
                    if (page_reg == op_reg.page_last)
                    begin
                        out_load       = 1'b1;
                        res_new.status = ST_OK;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        page_next = page_reg + PG_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + 8'd1;
                end
            end
            S_TICK:
            begin
                out_load            = 1'b1;
                res_new.bus_valid   = 1'b1;
                res_new.bus_is_data = 1'b1;
                res_new.bus_byte    = tick_col_ok ? rdata_reg : 8'd0;
                res_new.chip_select = (32'(tick_j) < CHIP_COLUMNS) ? CS_LEFT : CS_RIGHT;
                res_new.flush_last  = step_last && page_done;
                do_adv              = 1'b1;
                state_next          = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_adv)
        begin
            if (step_last)
            begin
                step_next = '0;
                if (page_done)
                begin
                    active_next    = 1'b0;
                    fpage_next     = '0;
                    fend_next      = '0;
                    low_page_next  = PG_W'(PAGES - 1);
                    high_page_next = '0;
                    dirty_next     = 1'b0;
                end
                else
                begin
                    fpage_next = fpage_reg + PG_W'(1);
                end
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            res_next       = res_new;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_pop;
            res_next       = res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            init_reg      <= 1'b1;
            clr_cnt_reg   <= '0;
            low_page_reg  <= PG_W'(PAGES - 1);
            high_page_reg <= '0;
            dirty_reg     <= 1'b0;
            active_reg    <= 1'b0;
            fpage_reg     <= '0;
            fend_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            clr_cnt_reg   <= clr_cnt_next;
            low_page_reg  <= low_page_next;
            high_page_reg <= high_page_next;
            dirty_reg     <= dirty_next;
            active_reg    <= active_next;
            fpage_reg     <= fpage_next;
            fend_reg      <= fend_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        col_reg  <= col_next;
        page_reg <= page_next;
        res_reg  <= res_next;
    end

endmodule

>>> rtl/mono_framebuffer_dirty_flush.sv
// Frame buffer top level: a status-only item or a flush command tick is answered from the idle
// state, a flush data tick after a store read, a plot or fill after a read and a write per byte
// touched, and a clear after the whole store is rewritten; all of these go through the store's one port.
// A waiting result blocks the back end, so it takes no new item while a result waits or an item is in work.
// After reset all WIDTH_PIXELS*PAGES bytes of the store (1024 by default) are zeroed with full high.
// Depends on mfdf_pkg, mfdf_front, mfdf_queue and mfdf_back.
module mono_framebuffer_dirty_flush #(
    parameter int WIDTH_PIXELS = mfdf_pkg::WIDTH_PIXELS_DEF,
    parameter int PAGES        = mfdf_pkg::PAGES_DEF,
    parameter int CHIP_COLUMNS = mfdf_pkg::CHIP_COLUMNS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] cmd,
    input  logic [6:0] x,
    input  logic [5:0] y,
    input  logic [7:0] length,
    input  logic [6:0] height,
    input  logic       inverse,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] status,
    output logic       bus_valid,
    output logic [7:0] bus_byte,
    output logic       bus_is_data,
    output logic [1:0] chip_select,
    output logic       flush_last
);
    import mfdf_pkg::*;

    logic    init_busy;
    logic    f_push;
    op_t     f_op;
    logic    q_full;
    logic    q_valid;
    op_t     q_op;
    logic    q_pop;
    logic    out_valid;
    result_t out_res;

    mfdf_front #(
        .WIDTH_PIXELS(WIDTH_PIXELS),
        .PAGES(PAGES)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .cmd(cmd),
        .x(x),
        .y(y),
        .length(length),
        .height(height),
        .inverse(inverse),
        .init_busy(init_busy),
        .q_push(f_push),
        .q_op(f_op),
        .q_full(q_full)
    );

    mfdf_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .wr(f_push),
        .wr_op(f_op),
        .q_full(q_full),
        .q_valid(q_valid),
        .rd_op(q_op),
        .rd(q_pop)
    );

    mfdf_back #(
        .WIDTH_PIXELS(WIDTH_PIXELS),
        .PAGES(PAGES),
        .CHIP_COLUMNS(CHIP_COLUMNS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_valid(q_valid),
        .q_op(q_op),
        .q_pop(q_pop),
        .init_busy(init_busy),
        .out_valid(out_valid),
        .out_res(out_res),
        .out_pop(pop)
    );

    assign empty       = !out_valid;
    assign status      = out_res.status;
    assign bus_valid   = out_res.bus_valid;
    assign bus_byte    = out_res.bus_byte;
    assign bus_is_data = out_res.bus_is_data;
    assign chip_select = out_res.chip_select;
    assign flush_last  = out_res.flush_last;

endmodule

>>> rtl/mfdf_checker.sv
// Port-level checker for the frame buffer block, bound to the top level.
// Depends on mfdf_pkg and the assertion macro header.
`include "mono_framebuffer_dirty_flush_macros.svh"

module mfdf_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [1:0] status,
    input logic       bus_valid,
    input logic [7:0] bus_byte,
    input logic       bus_is_data,
    input logic [1:0] chip_select,
    input logic       flush_last
);
    import mfdf_pkg::*;

    `MFDF_ASSERT_IMP(a_idle_fields_zero, clk, rst_n, !empty && !bus_valid, (bus_byte == 8'd0) && !bus_is_data && (chip_select == CS_LEFT) && !flush_last)
    `MFDF_ASSERT_IMP(a_last_is_right_data, clk, rst_n, !empty && flush_last, bus_valid && bus_is_data && (chip_select == CS_RIGHT) && (status == ST_OK))
    `MFDF_ASSERT_IMP(a_command_to_both, clk, rst_n, !empty && bus_valid && !bus_is_data, (chip_select == CS_BOTH) && (status == ST_OK))
    `MFDF_ASSERT_NXT(a_result_held, clk, rst_n, !empty && !pop, !empty)

endmodule

bind mono_framebuffer_dirty_flush mfdf_port_checker u_mfdf_checker (.*);

>>> tb/mfdf_checker.sv
// Checker for the monochrome frame buffer: watches both queue-style channels,
// keeps its own copy of the frame store and flush state, and compares every result item.
// Depends on mfdf_pkg for the command, status and chip-select codes and the result type.
module mfdf_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [2:0] cmd,
    input  logic [6:0] x,
    input  logic [5:0] y,
    input  logic [7:0] length,
    input  logic [6:0] height,
    input  logic       inverse,
    input  logic       empty,
    input  logic       pop,
    input  logic [1:0] status,
    input  logic       bus_valid,
    input  logic [7:0] bus_byte,
    input  logic       bus_is_data,
    input  logic [1:0] chip_select,
    input  logic       flush_last,
    output int         errors,
    output int         outstanding
);
    import mfdf_pkg::*;

    localparam int COLS = 128;
    localparam int ROWS = 64;
    localparam int BYTES = 1024;
    localparam int PAGE_TICKS = 130;

    logic [7:0] pixels [BYTES];
    int lo_mark, hi_mark, flush_pg, flush_end_pg, flush_step;
    bit dirty, flushing;
    result_t pending_results[$];

    assign outstanding = pending_results.size();

    function automatic void clear_marks();
        lo_mark = BYTES - 1;
        hi_mark = 0;
        dirty = 0;
    endfunction

    function automatic void widen(int first, int last);
        if (first < lo_mark) lo_mark = first;
        if (last > hi_mark) hi_mark = last;
    endfunction

    function automatic void paint(int col, int row, bit clr);
        int idx;
        idx = col + (row / 8) * COLS;
        if (clr)
            pixels[idx][row % 8] = 1'b0;
        else
            pixels[idx][row % 8] = 1'b1;
    endfunction

    function automatic result_t frame_response(logic [2:0] c, int px, int py, int len,
                                               int hgt, bit inv);
        result_t r;
        int j, idx, lo, hi;
        r = '0;
        r.status = ST_OK;
        if (c == CMD_TICK) begin
            if (!flushing) begin
                r.status = ST_IDLE;
            end
            else begin
                r.bus_valid = 1'b1;
                if (flush_step == 0) begin
                    r.bus_byte = LCD_PAGE_BASE + 8'(flush_pg);
                    r.chip_select = CS_BOTH;
                end
                else if (flush_step == 1) begin
                    r.bus_byte = LCD_COLUMN_ZERO;
                    r.chip_select = CS_BOTH;
                end
                else begin
                    j = flush_step - 2;
                    idx = flush_pg * COLS + j;
                    r.bus_is_data = 1'b1;
                    r.chip_select = (j < 64) ? CS_LEFT : CS_RIGHT;
                    if (j < COLS && idx < BYTES) r.bus_byte = pixels[idx];
                end
                flush_step++;
                if (flush_step >= PAGE_TICKS) begin
                    flush_step = 0;
                    if (flush_pg >= flush_end_pg) begin
                        r.flush_last = 1'b1;
                        flushing = 0;
                        flush_pg = 0;
                        flush_end_pg = 0;
                        clear_marks();
                    end
                    else begin
                        flush_pg++;
                    end
                end
            end
        end
        else if (c > CMD_FLUSH) begin
            r.status = ST_IDLE;
        end
        else if (flushing) begin
            r.status = ST_BUSY;
        end
        else if (c == CMD_PLOT) begin
            if (px >= COLS || py >= ROWS) begin
                r.status = ST_BORDER;
            end
            else begin
                paint(px, py, inv);
                widen(px + (py / 8) * COLS, px + (py / 8) * COLS);
                dirty = 1;
            end
        end
        else if (c == CMD_FILL) begin
            if (px >= COLS || py >= ROWS || px + len > COLS || py + hgt > ROWS) begin
                r.status = ST_BORDER;
            end
            else if (len != 0 && hgt != 0) begin
                for (int rr = py; rr < py + hgt; rr++)
                    for (int cc = px; cc < px + len; cc++)
                        paint(cc, rr, inv);
                widen(px + (py / 8) * COLS, (px + len - 1) + ((py + hgt - 1) / 8) * COLS);
                dirty = 1;
            end
        end
        else if (c == CMD_CLEAR) begin
            foreach (pixels[i]) pixels[i] = '0;
            lo_mark = 0;
            hi_mark = BYTES - 1;
            dirty = 1;
        end
        else begin
            if (!dirty) begin
                r.status = ST_IDLE;
            end
            else begin
                lo = (lo_mark >= BYTES) ? BYTES - 1 : lo_mark;
                hi = (hi_mark >= BYTES) ? BYTES - 1 : hi_mark;
                flush_pg = lo / COLS;
                flush_end_pg = hi / COLS;
                if (flush_end_pg < flush_pg) flush_end_pg = flush_pg;
                flush_step = 0;
                flushing = 1;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n) begin
            foreach (pixels[i]) pixels[i] = '0;
            clear_marks();
            flushing = 0;
            flush_pg = 0;
            flush_end_pg = 0;
            flush_step = 0;
            pending_results.delete();
            errors = 0;
        end
        else begin
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    $error("result item with no expectation waiting");
                    errors++;
                end
                else begin
                    want = pending_results.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        errors++;
                    end
                    if (bus_valid !== want.bus_valid) begin
                        $error("bus_valid: expected %0d, actual %0d", want.bus_valid, bus_valid);
                        errors++;
                    end
                    if (bus_byte !== want.bus_byte) begin
                        $error("bus_byte: expected %0h, actual %0h", want.bus_byte, bus_byte);
                        errors++;
                    end
                    if (bus_is_data !== want.bus_is_data) begin
                        $error("bus_is_data: expected %0d, actual %0d",
                               want.bus_is_data, bus_is_data);
                        errors++;
                    end
                    if (chip_select !== want.chip_select) begin
                        $error("chip_select: expected %0d, actual %0d",
                               want.chip_select, chip_select);
                        errors++;
                    end
                    if (flush_last !== want.flush_last) begin
                        $error("flush_last: expected %0d, actual %0d",
                               want.flush_last, flush_last);
                        errors++;
                    end
                end
            end
            if (push && !full)
                pending_results.push_back(frame_response(cmd, x, y, length, height, inverse));
        end
    end

endmodule

>>> tb/testbench.sv
// Top of the frame buffer testbench: clock, reset, directed and random item stimulus,
// result-side stalls and the verdict. Depends on mfdf_pkg, mfdf_checker and the block.
module testbench;
    import mfdf_pkg::*;

    localparam int ITEM_COUNT = 1750;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [2:0] cmd = CMD_TICK;
    logic [6:0] x = '0;
    logic [5:0] y = '0;
    logic [7:0] length = '0;
    logic [6:0] height = '0;
    logic       inverse = 1'b0;
    logic       pop = 1'b0;
    logic       full, empty, bus_valid, bus_is_data, flush_last;
    logic [1:0] status, chip_select;
    logic [7:0] bus_byte;
    int         errors, outstanding;
    bit         calm = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    mono_framebuffer_dirty_flush uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd), .x(x), .y(y),
        .length(length), .height(height), .inverse(inverse), .empty(empty), .pop(pop),
        .status(status), .bus_valid(bus_valid), .bus_byte(bus_byte),
        .bus_is_data(bus_is_data), .chip_select(chip_select), .flush_last(flush_last)
    );

    mfdf_checker frame_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd), .x(x), .y(y),
        .length(length), .height(height), .inverse(inverse), .empty(empty), .pop(pop),
        .status(status), .bus_valid(bus_valid), .bus_byte(bus_byte),
        .bus_is_data(bus_is_data), .chip_select(chip_select), .flush_last(flush_last),
        .errors(errors), .outstanding(outstanding)
    );

    task automatic send_item(logic [2:0] c, int px, int py, int len, int hgt, bit inv);
        if (!calm && $urandom_range(0, 11) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        push <= 1'b1;
        cmd <= c;
        x <= 7'(px);
        y <= 6'(py);
        length <= 8'(len);
        height <= 7'(hgt);
        inverse <= inv;
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_item();
        int pick, len, hgt;
        pick = $urandom_range(0, 99);
        len = $urandom_range(0, 8);
        hgt = $urandom_range(0, 12);
        if ($urandom_range(0, 39) == 0) begin
            len = $urandom_range(0, 255);
            hgt = $urandom_range(0, 127);
        end
        if (pick < 45)
            send_item(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 65)
            send_item(CMD_PLOT, $urandom_range(0, 127), $urandom_range(0, 63),
                      $urandom, $urandom, $urandom);
        else if (pick < 83)
            send_item(CMD_FILL, $urandom_range(0, 127), $urandom_range(0, 63),
                      len, hgt, $urandom);
        else if (pick < 92)
            send_item(CMD_FLUSH, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 94)
            send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            send_item(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom,
                      $urandom);
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        for (int cyc = 0; ; cyc++) begin
            @(negedge clk);
            if (cyc == 8000) stall_left = 3000;
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end
            else begin
                pop <= 1'b1;
                if (!calm && $urandom_range(0, 13) == 0) stall_left = $urandom_range(1, 17);
            end
        end
    end

    initial
    begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int waited;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_item(CMD_FLUSH, 0, 0, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 0, 0, 0);
        send_item(CMD_PLOT, 0, 0, 0, 0, 0);
        send_item(CMD_PLOT, 127, 63, 0, 0, 0);
        send_item(CMD_PLOT, 127, 63, 0, 0, 1);
        send_item(CMD_FILL, 0, 0, 128, 64, 0);
        send_item(CMD_FILL, 120, 0, 9, 1, 0);
        send_item(CMD_FILL, 0, 60, 1, 5, 0);
        send_item(CMD_FILL, 127, 63, 255, 127, 1);
        send_item(CMD_FILL, 5, 5, 0, 3, 0);
        send_item(CMD_FILL, 5, 5, 3, 0, 0);
        send_item(CMD_FILL, 3, 7, 10, 3, 1);
        send_item(3'd5, 0, 0, 0, 0, 0);
        send_item(3'd6, 0, 0, 0, 0, 0);
        send_item(3'd7, 127, 63, 255, 127, 1);
        send_item(CMD_FLUSH, 0, 0, 0, 0, 0);
        send_item(CMD_PLOT, 1, 1, 0, 0, 0);
        send_item(CMD_FILL, 1, 1, 2, 2, 0);
        send_item(CMD_CLEAR, 0, 0, 0, 0, 0);
        send_item(CMD_FLUSH, 0, 0, 0, 0, 0);
        for (int i = 0; i < 300; i++) send_item(CMD_TICK, 0, 0, 0, 0, 0);
        send_item(CMD_CLEAR, 0, 0, 0, 0, 0);
        send_item(CMD_FILL, 64, 8, 64, 8, 0);
        for (int i = 0; i < ITEM_COUNT; i++) begin
            if (i == ITEM_COUNT / 2) begin
                push <= 1'b0;
                wait (outstanding == 0);
                @(negedge clk);
            end
            if (i == ITEM_COUNT - 200) calm = 1;
            send_random_item();
        end
        push <= 1'b0;
        wait (outstanding == 0);
        repeat (50) @(negedge clk);
        if (errors == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> mono_framebuffer_dirty_flush.f
+incdir+rtl
rtl/mfdf_pkg.sv
rtl/mfdf_front.sv
rtl/mfdf_queue.sv
rtl/mfdf_back.sv
rtl/mono_framebuffer_dirty_flush.sv
rtl/mfdf_checker.sv
tb/mfdf_checker.sv
tb/testbench.sv
